// ----- rtl/core/sec2cal_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Seconds to calendar conversion package
// Epoch settings, calendar constants and reciprocals for the constant
// divisions of the conversion pipeline.
// ----------------------------------------------------------------------------
package sec2cal_pkg;

  localparam int unsigned EPOCH_YEAR    = 1970;
  localparam int unsigned EPOCH_WEEKDAY = 4;

  localparam int unsigned BASE_YEAR    = 1600;
  localparam int unsigned ERA_YEARS    = 400;
  localparam int unsigned ERA_DAYS     = 146097;
  localparam int unsigned CENT_DAYS    = 36524;
  localparam int unsigned QUAD_DAYS    = 1461;
  localparam int unsigned YEAR_DAYS    = 365;
  localparam int unsigned SECS_PER_MIN = 60;
  localparam int unsigned MINS_PER_HR  = 60;
  localparam int unsigned WEEK_DAYS    = 7;

  // Month index counted from March; January and February come last.
  localparam logic [3:0] MP_JAN = 4'd10;
  localparam logic [3:0] MP_MAR_OFS = 4'd3;
  localparam logic [3:0] MP_JAN_OFS = 4'd9;

  // Seconds per day is 675 * 2^7; divide the upper 25 bits by 675.
  localparam int unsigned     DAY_DIV   = 675;
  localparam int unsigned     DAY_SHIFT = 35;
  localparam longint unsigned DAY_RECIP_L =
    ((64'd1 << DAY_SHIFT) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV);
  localparam logic [25:0]     DAY_RECIP = 26'(DAY_RECIP_L);

  // Seconds of day / 60 as (tod >> 2) / 15.
  localparam int unsigned TOD_RECIP = ((1 << 19) + 14) / 15;
  // Minutes of day / 60 as (mt >> 2) / 15.
  localparam int unsigned HR_RECIP  = ((1 << 13) + 14) / 15;
  // Weekday sum / 7.
  localparam int unsigned WD_RECIP  = ((1 << 19) + WEEK_DAYS - 1) / WEEK_DAYS;
  // Day of century / 1461.
  localparam int unsigned Q_RECIP   = ((1 << 27) + QUAD_DAYS - 1) / QUAD_DAYS;
  // (5 * day of year + 2) / 153.
  localparam int unsigned MP_RECIP  = ((1 << 19) + 152) / 153;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } sec2cal_tw_t;

  // Days from March 1, 1600 to January 1 of year y.
  function automatic int unsigned epoch_offset(input int unsigned y);
    int unsigned yp;
    int unsigned yoe;
    int unsigned doe;
    yp  = y - 1;
    yoe = yp % 400;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + 306;
    return (yp / 400 - 4) * ERA_DAYS + doe;
  endfunction

  localparam int unsigned EPOCH_OFFSET = epoch_offset(EPOCH_YEAR);

  // First day of year (from March 1) of each month index.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] ms;
    unique case (mp)
      4'd0:    ms = 9'd0;
      4'd1:    ms = 9'd31;
      4'd2:    ms = 9'd61;
      4'd3:    ms = 9'd92;
      4'd4:    ms = 9'd122;
      4'd5:    ms = 9'd153;
      4'd6:    ms = 9'd184;
      4'd7:    ms = 9'd214;
      4'd8:    ms = 9'd245;
      4'd9:    ms = 9'd275;
      4'd10:   ms = 9'd306;
      4'd11:   ms = 9'd337;
      default: ms = 9'd0;
    endcase
    return ms;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/seconds_to_calendar_datetime.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Seconds count to calendar date and time
// Pipelined conversion of a 32-bit seconds count into year, month, day,
// weekday, hour, minute and second.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_epoch_seconds and pulse start; a transaction is taken at each
//   rising edge with start high and busy low. busy is high only while rst_n
//   is low, so a new count may enter every cycle (one transaction per cycle
//   sustained).
//   The result shows on the out_ ports for exactly one cycle with out_valid
//   high, after it passes through the ten register stages of the pipeline
//   (split by reciprocal multiplies, then era, century, leap cycle, year and
//   month reduction).
//   Results leave in input order. The receiver cannot stall: a result not
//   taken in its cycle is gone.
//   Synchronous reset (rst_n low) drops every transaction in flight;
//   out_valid is low in the cycle after reset.
// ----------------------------------------------------------------------------
module seconds_to_calendar_datetime (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_epoch_seconds,
  output logic             out_valid,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day_of_month,
  output logic [2:0]       out_weekday,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second
);
  import sec2cal_pkg::*;

  logic        accept;
  logic [9:0]  vld_r;

  logic [31:0] secs_r;
  logic [15:0] day1_r;
  logic [24:0] x1_r;
  logic [6:0]  lo1_r;
  logic [16:0] tod2_r;
  logic [17:0] z2_r;
  logic [15:0] w2_r;
  logic [16:0] tod3_r;
  logic [10:0] mt3_r;
  logic [17:0] doe3_r;
  logic [15:0] w3_r;
  logic [12:0] wq3_r;
  logic [5:0]  sec4_r;
  logic [4:0]  hour4_r;
  logic [10:0] mt4_r;
  logic [1:0]  c4_r;
  logic [15:0] doc4_r;
  logic [2:0]  wd4_r;
  sec2cal_tw_t tw5_r;
  logic [1:0]  c5_r;
  logic [15:0] doc5_r;
  logic [4:0]  q5_r;
  logic [10:0] doq6_r;
  logic [8:0]  ycq6_r;
  logic [8:0]  doy7_r;
  logic [8:0]  yoe7_r;
  logic [8:0]  doy8_r;
  logic [8:0]  yoe8_r;
  logic [3:0]  mp8_r;
  logic [8:3]  era_r;
  sec2cal_tw_t tw_r [6:8];

  logic [50:0] day_prod;
  logic [15:0] day1_nxt;
  logic [25:0] day_back;
  logic [25:0] day_rem;
  logic [16:0] tod2_nxt;
  logic [30:0] tod_prod;
  logic [10:0] mt3_nxt;
  logic        era3_nxt;
  logic [17:0] doe3_nxt;
  logic [32:0] wd_prod;
  logic [12:0] wq3_nxt;
  logic [5:0]  sec4_nxt;
  logic [18:0] hr_prod;
  logic [4:0]  hour4_nxt;
  logic [1:0]  c4_nxt;
  logic [17:0] cent_base;
  logic [15:0] doc4_nxt;
  logic [2:0]  wd4_nxt;
  logic [5:0]  min5_nxt;
  logic [32:0] q_prod;
  logic [4:0]  q5_nxt;
  logic [10:0] doq6_nxt;
  logic [8:0]  ycq6_nxt;
  logic [1:0]  yq7;
  logic [8:0]  doy7_nxt;
  logic [10:0] mp_arg;
  logic [22:0] mp_prod;
  logic [3:0]  mp8_nxt;
  logic [4:0]  day9_nxt;
  logic [3:0]  month9_nxt;
  logic [11:0] year9_nxt;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  always_comb begin
    // Whole days and seconds of day.
    day_prod = 51'(secs_r[31:7]) * 51'(DAY_RECIP);
    day1_nxt = day_prod[50:35];
    day_back = 26'(day1_r) * 26'(DAY_DIV);
    day_rem  = 26'(x1_r) - day_back;
    tod2_nxt = {day_rem[9:0], lo1_r};

    // Time of day.
    tod_prod  = 31'(tod2_r[16:2]) * 31'(TOD_RECIP);
    mt3_nxt   = tod_prod[29:19];
    sec4_nxt  = 6'(tod3_r - 17'(mt3_r) * 17'(SECS_PER_MIN));
    hr_prod   = 19'(mt3_r[10:2]) * 19'(HR_RECIP);
    hour4_nxt = hr_prod[17:13];
    min5_nxt  = 6'(mt4_r - 11'(hour4_r) * 11'(MINS_PER_HR));

    // Weekday.
    wd_prod = 33'(w2_r) * 33'(WD_RECIP);
    wq3_nxt = wd_prod[31:19];
    wd4_nxt = 3'(w3_r - 16'(wq3_r) * 16'(WEEK_DAYS));

    // Era and day of era, counted from March 1, 1600.
    era3_nxt = (z2_r >= 18'(ERA_DAYS));
    doe3_nxt = era3_nxt ? (z2_r - 18'(ERA_DAYS)) : z2_r;

    // Century within era; the last century is one day longer.
    priority if (doe3_r >= 18'(3 * CENT_DAYS)) begin
      c4_nxt = 2'd3;
    end else if (doe3_r >= 18'(2 * CENT_DAYS)) begin
      c4_nxt = 2'd2;
    end else if (doe3_r >= 18'(CENT_DAYS)) begin
      c4_nxt = 2'd1;
    end else begin
      c4_nxt = 2'd0;
    end
    cent_base = 18'(c4_nxt) * 18'(CENT_DAYS);
    doc4_nxt  = 16'(doe3_r - cent_base);

    // Leap cycle within century.
    q_prod   = 33'(doc4_r) * 33'(Q_RECIP);
    q5_nxt   = q_prod[31:27];
    doq6_nxt = 11'(doc5_r - 16'(q5_r) * 16'(QUAD_DAYS));
    ycq6_nxt = 9'(c5_r) * 9'd100 + {2'b00, q5_r, 2'b00};

    // Year within leap cycle; the last year is one day longer.
    priority if (doq6_r >= 11'(3 * YEAR_DAYS)) begin
      yq7 = 2'd3;
    end else if (doq6_r >= 11'(2 * YEAR_DAYS)) begin
      yq7 = 2'd2;
    end else if (doq6_r >= 11'(YEAR_DAYS)) begin
      yq7 = 2'd1;
    end else begin
      yq7 = 2'd0;
    end
    doy7_nxt = 9'(doq6_r - 11'(yq7) * 11'(YEAR_DAYS));

    // Month index from March.
    mp_arg  = 11'(doy7_r) * 11'd5 + 11'd2;
    mp_prod = 23'(mp_arg) * 23'(MP_RECIP);
    mp8_nxt = mp_prod[22:19];

    day9_nxt   = 5'(doy8_r - month_start(mp8_r) + 9'd1);
    month9_nxt = (mp8_r < MP_JAN) ? (mp8_r + MP_MAR_OFS) : (mp8_r - MP_JAN_OFS);
    year9_nxt  = 12'(BASE_YEAR) + (era_r[8] ? 12'(ERA_YEARS) : 12'd0)
                 + 12'(yoe8_r) + 12'(mp8_r >= MP_JAN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[8:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    secs_r <= in_epoch_seconds;

    day1_r <= day1_nxt;
    x1_r   <= secs_r[31:7];
    lo1_r  <= secs_r[6:0];

    tod2_r <= tod2_nxt;
    z2_r   <= 18'(day1_r) + 18'(EPOCH_OFFSET);
    w2_r   <= day1_r + 16'(EPOCH_WEEKDAY);

    tod3_r   <= tod2_r;
    mt3_r    <= mt3_nxt;
    era_r[3] <= era3_nxt;
    doe3_r   <= doe3_nxt;
    w3_r     <= w2_r;
    wq3_r    <= wq3_nxt;

    sec4_r  <= sec4_nxt;
    hour4_r <= hour4_nxt;
    mt4_r   <= mt3_r;
    c4_r    <= c4_nxt;
    doc4_r  <= doc4_nxt;
    wd4_r   <= wd4_nxt;

    tw5_r.hour    <= hour4_r;
    tw5_r.minute  <= min5_nxt;
    tw5_r.second  <= sec4_r;
    tw5_r.weekday <= wd4_r;
    c5_r          <= c4_r;
    doc5_r        <= doc4_r;
    q5_r          <= q5_nxt;

    doq6_r <= doq6_nxt;
    ycq6_r <= ycq6_nxt;

    doy7_r <= doy7_nxt;
    yoe7_r <= ycq6_r + 9'(yq7);

    doy8_r <= doy7_r;
    yoe8_r <= yoe7_r;
    mp8_r  <= mp8_nxt;

    era_r[8:4] <= era_r[7:3];
    tw_r[6]    <= tw5_r;
    tw_r[7]    <= tw_r[6];
    tw_r[8]    <= tw_r[7];

    out_year         <= year9_nxt;
    out_month        <= month9_nxt;
    out_day_of_month <= day9_nxt;
    out_weekday      <= tw_r[8].weekday;
    out_hour         <= tw_r[8].hour;
    out_minute       <= tw_r[8].minute;
    out_second       <= tw_r[8].second;
  end

  assign out_valid = vld_r[9];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##10 out_valid)
    else $error("transaction did not reach the output on time");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1) && (out_month <= 4'd12) &&
                  (out_day_of_month >= 5'd1))
    else $error("month or day out of range");

  a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_month == 4'd2) |-> (out_day_of_month <= 5'd29))
    else $error("February day beyond 29");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour < 5'd24) && (out_minute < 6'd60) &&
                  (out_second < 6'd60) && (out_weekday < 3'd7))
    else $error("time of day or weekday out of range");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for seconds_to_calendar_datetime
// Feeds seconds counts (directed calendar corners, then random counts biased
// toward day, month and year boundaries) through a queue-fed driver with
// random idle bursts, and checks every result against a calendar predictor
// that walks the days year by year and month by month.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned DAY_SECS    = 86400;
  localparam int unsigned LAST_DAY    = 49709;
  localparam int unsigned LAST_YEAR   = 2105;
  localparam int unsigned RANDOM_CNT  = 600;
  localparam int unsigned CALM_TAIL   = 60;
  localparam int unsigned DRAIN_WAIT  = 24;
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [31:0] secs;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_epoch_seconds;
  logic        out_valid;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [2:0]  out_weekday;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;

  logic [31:0] pending_counts[$];
  calendar_t   expected_dates[$];
  logic        taken;
  int unsigned idle_left;
  int unsigned cycle_cnt;
  int unsigned accepted_cnt;
  int unsigned checked_cnt;
  int unsigned error_cnt;

  seconds_to_calendar_datetime dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_weekday      (out_weekday),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned year_length(input int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    int unsigned n;
    n = MONTH_DAYS[m - 1];
    if (m == 2 && leap_year(y)) begin
      n = n + 1;
    end
    return n;
  endfunction

  function automatic int unsigned year_first_day(input int unsigned y);
    int unsigned d;
    d = 0;
    for (int unsigned k = sec2cal_pkg::EPOCH_YEAR; k < y; k++) begin
      d = d + year_length(k);
    end
    return d;
  endfunction

  function automatic calendar_t calendar_of(input logic [31:0] secs);
    calendar_t   c;
    int unsigned day_idx;
    int unsigned tod;
    int unsigned days;
    int unsigned yr;
    int unsigned mo;
    day_idx = secs / DAY_SECS;
    tod     = secs % DAY_SECS;
    days    = day_idx;
    yr      = sec2cal_pkg::EPOCH_YEAR;
    mo      = 1;
    while (days >= year_length(yr)) begin
      days = days - year_length(yr);
      yr   = yr + 1;
    end
    while (mo < 12 && days >= month_length(mo, yr)) begin
      days = days - month_length(mo, yr);
      mo   = mo + 1;
    end
    c.secs         = secs;
    c.year         = 12'(yr);
    c.month        = 4'(mo);
    c.day_of_month = 5'(days + 1);
    c.weekday      = 3'((longint'(day_idx) + sec2cal_pkg::EPOCH_WEEKDAY) % 7);
    c.hour         = 5'(tod / 3600);
    c.minute       = 6'((tod % 3600) / 60);
    c.second       = 6'(tod % 60);
    return c;
  endfunction

  task automatic check_field(input string name, input logic [31:0] secs,
                             input int unsigned exp_v, input int unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s for count %0d: expected %0d, got %0d", name, secs, exp_v, act_v);
      error_cnt++;
    end
  endtask

  // Stimulus: directed corners, then random counts.
  initial begin
    int unsigned sel;
    int unsigned y;
    int unsigned d;
    longint      day_l;
    longint      secs_l;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_epoch_seconds = 32'd0;

    pending_counts.push_back(32'd0);
    pending_counts.push_back(32'hFFFF_FFFF);
    pending_counts.push_back(32'd86399);
    pending_counts.push_back(32'd86400);
    pending_counts.push_back(32'd31535999);
    pending_counts.push_back(32'd31536000);
    pending_counts.push_back(32'd68169600);
    pending_counts.push_back(32'd68255999);
    pending_counts.push_back(32'd68256000);
    pending_counts.push_back(32'd94694399);
    pending_counts.push_back(32'd951782400);
    pending_counts.push_back(32'd951868800);
    pending_counts.push_back(32'd978307199);
    pending_counts.push_back(32'd4107456000);
    pending_counts.push_back(32'd4107542399);
    pending_counts.push_back(32'd4107542400);
    pending_counts.push_back(32'h7FFF_FFFF);
    pending_counts.push_back(32'h8000_0000);
    pending_counts.push_back(32'hAAAA_AAAA);
    pending_counts.push_back(32'h5555_5555);
    pending_counts.push_back(32'd4294944000);

    for (int i = 0; i < RANDOM_CNT; i++) begin
      sel = $urandom_range(0, 2);
      if (sel == 0) begin
        pending_counts.push_back($urandom);
      end else if (sel == 1) begin
        day_l  = $urandom_range(0, LAST_DAY);
        secs_l = day_l * DAY_SECS +
                 ($urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(86397, 86399));
        pending_counts.push_back(32'(secs_l));
      end else begin
        // land on the edges of a year or of the end of February
        y = $urandom_range(sec2cal_pkg::EPOCH_YEAR, LAST_YEAR);
        d = year_first_day(y);
        case ($urandom_range(0, 4))
          0: day_l = longint'(d) - 1;
          1: day_l = d;
          2: day_l = d + 58;
          3: day_l = d + 59;
          default: day_l = d + 60;
        endcase
        if (day_l < 0) day_l = 0;
        if (day_l > LAST_DAY) day_l = LAST_DAY;
        secs_l = day_l * DAY_SECS + $urandom_range(0, DAY_SECS - 1);
        pending_counts.push_back(32'(secs_l));
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (pending_counts.size() != 0 || (start && !taken));
    do @(posedge clk); while (expected_dates.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Converted %0d seconds counts (calendar corners and boundary-biased random)",
             accepted_cnt);
    $display("Compared %0d results field by field, %0d mismatches", checked_cnt, error_cnt);
    if (error_cnt == 0 && expected_dates.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Driver: hold a transaction until taken, then advance or idle.
  always @(negedge clk) begin
    if (rst_n && !(start && !taken)) begin
      if (idle_left > 0) begin
        start     <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (pending_counts.size() > 0) begin
        if (pending_counts.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
          start     <= 1'b0;
          idle_left <= $urandom_range(1, 16) - 1;
        end else begin
          start            <= 1'b1;
          in_epoch_seconds <= pending_counts.pop_front();
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: record accepted counts, check results against the oldest prediction.
  always @(posedge clk) begin
    calendar_t want;
    if (!rst_n) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (start && !busy) begin
        expected_dates.push_back(calendar_of(in_epoch_seconds));
        accepted_cnt++;
      end
      if (out_valid) begin
        if (expected_dates.size() == 0) begin
          $error("result with no pending transaction: year %0d month %0d day %0d",
                 out_year, out_month, out_day_of_month);
          error_cnt++;
        end else begin
          want = expected_dates.pop_front();
          checked_cnt++;
          check_field("year", want.secs, want.year, out_year);
          check_field("month", want.secs, want.month, out_month);
          check_field("day_of_month", want.secs, want.day_of_month, out_day_of_month);
          check_field("weekday", want.secs, want.weekday, out_weekday);
          check_field("hour", want.secs, want.hour, out_hour);
          check_field("minute", want.secs, want.minute, out_minute);
          check_field("second", want.secs, want.second, out_second);
        end
      end
    end
  end

  initial begin
    taken     = 1'b0;
    idle_left = 0;
    cycle_cnt = 0;
    accepted_cnt = 0;
    checked_cnt  = 0;
    error_cnt    = 0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
